// ===== rtl/core/rgbenc_pkg.sv =====
// rgbenc_pkg: shared constants and types for the rgb led pulse encoder
// no dependencies
package rgbenc_pkg;

	localparam int FRAME_BITS = 24;
	localparam int CNT_W      = $clog2(FRAME_BITS);
	localparam int CHAN_W     = 8;
	localparam int TICK_W     = 15;
	localparam int COLOUR_W   = 3 * CHAN_W;
	localparam int PROD_W     = 2 * CHAN_W;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam logic [COLOUR_W-1:0] COLOUR_MASK = 24'hFF_FFFF;

	typedef enum logic [1:0] {
		REG_ZERO_HIGH = 2'd0,
		REG_ZERO_LOW  = 2'd1,
		REG_ONE_HIGH  = 2'd2,
		REG_ONE_LOW   = 2'd3
	} reg_idx_t;

	typedef logic [TICK_W-1:0] tick_t;
	typedef logic [CHAN_W-1:0] chan_t;

	// floor(c * b / 255), exact for any 16-bit product
	function automatic chan_t scale_chan(input chan_t c, input chan_t b);
		logic [PROD_W-1:0] p;
		logic [PROD_W:0]   s;
		p = c * b;
		s = {1'b0, p} + {9'b0, p[PROD_W-1:CHAN_W]} + 17'd1;
		return s[PROD_W-1:CHAN_W];
	endfunction

endpackage

// ===== rtl/core/rgb_led_pulse_encoder.sv =====
// rgb_led_pulse_encoder: an accepted command passes the input register into the bit shifter before its first bit beat
// throughput one frame of FRAME_BITS beats per command, one beat every cycle, back to back,
// set by the single bit shifter; the next command waits in the input register
// results cannot be stalled; asynchronous active-low reset clears control state and
// restores the default tick registers
module rgb_led_pulse_encoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [rgbenc_pkg::CHAN_W-1:0]       red,
	input  logic [rgbenc_pkg::CHAN_W-1:0]       green,
	input  logic [rgbenc_pkg::CHAN_W-1:0]       blue,
	input  logic [rgbenc_pkg::CHAN_W-1:0]       bright,
	output logic                                strobe,
	output logic [rgbenc_pkg::TICK_W-1:0]       high_ticks,
	output logic [rgbenc_pkg::TICK_W-1:0]       low_ticks,
	output logic                                bit_value,
	output logic                                last_bit,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rgbenc_pkg::ADDR_W-1:0]       paddr,
	input  logic [rgbenc_pkg::DATA_W-1:0]       pwdata,
	output logic [rgbenc_pkg::DATA_W-1:0]       prdata,
	output logic                                pready
);

	rgbenc_pkg::tick_t zero_high_q, zero_low_q, one_high_q, one_low_q;

	logic                          valid_s1;
	rgbenc_pkg::chan_t             red_s1, green_s1, blue_s1, bright_s1;

	logic                                   active_q;
	logic [rgbenc_pkg::CNT_W-1:0]           count_q;
	logic [rgbenc_pkg::FRAME_BITS-1:0]      shift_q;

	logic                                   last_beat;
	logic                                   free;
	logic                                   accept;
	logic                                   wr_en;
	rgbenc_pkg::reg_idx_t                   wr_idx;
	logic [rgbenc_pkg::COLOUR_W-1:0]        colour;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign wr_idx = rgbenc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_high_q <= 15'd14;
			zero_low_q  <= 15'd32;
			one_high_q  <= 15'd28;
			one_low_q   <= 15'd24;
		end else if (wr_en) begin
			case (wr_idx)
				rgbenc_pkg::REG_ZERO_HIGH: zero_high_q <= pwdata[rgbenc_pkg::TICK_W-1:0];
				rgbenc_pkg::REG_ZERO_LOW:  zero_low_q  <= pwdata[rgbenc_pkg::TICK_W-1:0];
				rgbenc_pkg::REG_ONE_HIGH:  one_high_q  <= pwdata[rgbenc_pkg::TICK_W-1:0];
				rgbenc_pkg::REG_ONE_LOW:   one_low_q   <= pwdata[rgbenc_pkg::TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (wr_idx)
			rgbenc_pkg::REG_ZERO_HIGH: prdata = {17'b0, zero_high_q};
			rgbenc_pkg::REG_ZERO_LOW:  prdata = {17'b0, zero_low_q};
			rgbenc_pkg::REG_ONE_HIGH:  prdata = {17'b0, one_high_q};
			rgbenc_pkg::REG_ONE_LOW:   prdata = {17'b0, one_low_q};
			default:                   prdata = '0;
		endcase
	end

	assign last_beat = active_q &&
		(count_q == rgbenc_pkg::CNT_W'(rgbenc_pkg::FRAME_BITS - 1));
	assign free   = !active_q || last_beat;
	assign busy   = valid_s1 && !free;
	assign accept = start && !busy;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (free) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1    <= red;
			green_s1  <= green;
			blue_s1   <= blue;
			bright_s1 <= bright;
		end
	end

	// scale and pack, red high
	assign colour = {rgbenc_pkg::scale_chan(red_s1, bright_s1),
		rgbenc_pkg::scale_chan(green_s1, bright_s1),
		rgbenc_pkg::scale_chan(blue_s1, bright_s1)} & rgbenc_pkg::COLOUR_MASK;

	// bit shifter, msb first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			count_q  <= '0;
		end else if (free && valid_s1) begin
			active_q <= 1'b1;
			count_q  <= '0;
		end else if (last_beat) begin
			active_q <= 1'b0;
			count_q  <= '0;
		end else if (active_q) begin
			count_q  <= count_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && valid_s1) begin
			shift_q <= rgbenc_pkg::FRAME_BITS'(colour);
		end else if (active_q) begin
			shift_q <= {shift_q[rgbenc_pkg::FRAME_BITS-2:0], 1'b0};
		end
	end

	assign strobe     = active_q;
	assign bit_value  = shift_q[rgbenc_pkg::FRAME_BITS-1];
	assign high_ticks = bit_value ? one_high_q : zero_high_q;
	assign low_ticks  = bit_value ? one_low_q : zero_low_q;
	assign last_bit   = last_beat;

endmodule

// ===== rtl/core/rgbenc_checker.sv =====
// rgbenc_checker: port-level checks for the rgb led pulse encoder
// depends on rgb_led_pulse_encoder; bound to it below
module rgbenc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic strobe,
	input logic last_bit
);

	// last marker only on a beat
	a_last_on_beat: assert property (@(posedge clk) disable iff (!arst_n)
		last_bit |-> strobe)
		else $error("last_bit without strobe");

	// a frame runs without gaps
	a_frame_contig: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_bit |=> strobe)
		else $error("gap inside frame");

	// no two last markers in a row
	a_last_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_bit |=> !last_bit)
		else $error("consecutive last beats");

	// command into an idle encoder starts its frame once it has passed the input register and the bit shifter
	a_start_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !strobe |-> ##2 strobe)
		else $error("frame did not start");

	// busy only rises while a frame is in flight
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> strobe)
		else $error("busy without frame in flight");

endmodule

bind rgb_led_pulse_encoder rgbenc_checker u_rgbenc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.strobe   (strobe),
	.last_bit (last_bit)
);

// ===== test/tb_rgb_led_pulse_encoder.sv =====
// tb_rgb_led_pulse_encoder: self-checking bench for the rgb led pulse encoder
// drives colour commands and apb register beats, predicts every pulse beat and compares it
// depends on rgbenc_pkg and rgb_led_pulse_encoder
module tb_rgb_led_pulse_encoder;
	import rgbenc_pkg::*;

	localparam int HALF_PERIOD  = 2;
	localparam int RESET_CYCLES = 6;
	localparam int IDLE_LIMIT   = 2000;
	localparam int TAIL_CYCLES  = 8;
	localparam int NUM_REGS     = 4;
	localparam int NUM_PHASES   = 6;
	localparam int RANDOM_CMDS  = 78;
	localparam int FULL_SCALE   = 255;
	localparam int NUM_DIRECTED = 14;

	localparam tick_t TICK_MAX = '1;

	typedef logic [COLOUR_W-1:0] colour_t;

	typedef struct packed {
		tick_t high_ticks;
		tick_t low_ticks;
		logic  bit_value;
		logic  last_bit;
	} pulse_beat_t;

	typedef struct packed {
		chan_t   red;
		chan_t   green;
		chan_t   blue;
		chan_t   bright;
		logic    typed;
		colour_t frame;
	} colour_cmd_t;

	// typed rows carry the frame as it must go out on the wire
	localparam colour_cmd_t DIRECTED_CMDS [NUM_DIRECTED] = '{
		'{8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 24'h00_0000},
		'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 24'hFF_FFFF},
		'{8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 24'h00_0000},
		'{8'h00, 8'h00, 8'h00, 8'hFF, 1'b1, 24'h00_0000},
		'{8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1, 24'hFF_0000},
		'{8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1, 24'h00_FF00},
		'{8'h00, 8'h00, 8'hFF, 8'hFF, 1'b1, 24'h00_00FF},
		'{8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b1, 24'h01_0101},
		'{8'h01, 8'h01, 8'h01, 8'hFF, 1'b1, 24'h01_0101},
		'{8'hAA, 8'h55, 8'hAA, 8'hFF, 1'b1, 24'hAA_55AA},
		'{8'h80, 8'h01, 8'h7F, 8'hFF, 1'b1, 24'h80_017F},
		'{8'hFE, 8'hFE, 8'hFE, 8'hFE, 1'b0, 24'h00_0000},
		'{8'h80, 8'h40, 8'h20, 8'h80, 1'b0, 24'h00_0000},
		'{8'h01, 8'hFF, 8'h7F, 8'hFE, 1'b0, 24'h00_0000}
	};

	logic                clk     = 1'b0;
	logic                arst_n  = 1'b0;
	logic                start   = 1'b0;
	logic                busy;
	chan_t               red     = '0;
	chan_t               green   = '0;
	chan_t               blue    = '0;
	chan_t               bright  = '0;
	logic                strobe;
	tick_t               high_ticks;
	tick_t               low_ticks;
	logic                bit_value;
	logic                last_bit;
	logic                psel    = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite  = 1'b0;
	logic [ADDR_W-1:0]   paddr   = '0;
	logic [DATA_W-1:0]   pwdata  = '0;
	logic [DATA_W-1:0]   prdata;
	logic                pready;

	tick_t       tick_regs [NUM_REGS];
	pulse_beat_t beats_due [$];
	int          fail_count  = 0;
	int          idle_cycles = 0;

	rgb_led_pulse_encoder i_dut (.*);

	always #HALF_PERIOD clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		fail_count++;
	endtask

	function automatic chan_t dimmed(input chan_t c, input chan_t br);
		return chan_t'((int'(c) * int'(br)) / FULL_SCALE);
	endfunction

	function automatic colour_t scaled_frame(input colour_cmd_t cmd);
		return {dimmed(cmd.red, cmd.bright), dimmed(cmd.green, cmd.bright),
			dimmed(cmd.blue, cmd.bright)};
	endfunction

	// msb first, durations picked by the bit value under the current tick setting
	function automatic void push_frame(input colour_t colour);
		logic [FRAME_BITS-1:0] bits;
		pulse_beat_t           beat;
		bits = FRAME_BITS'(colour);
		for (int k = FRAME_BITS - 1; k >= 0; k--) begin
			beat.bit_value  = bits[k];
			beat.high_ticks = bits[k] ? tick_regs[REG_ONE_HIGH] : tick_regs[REG_ZERO_HIGH];
			beat.low_ticks  = bits[k] ? tick_regs[REG_ONE_LOW] : tick_regs[REG_ZERO_LOW];
			beat.last_bit   = (k == 0);
			beats_due.push_back(beat);
		end
	endfunction

	function automatic colour_cmd_t random_colour();
		colour_cmd_t cmd;
		cmd.red   = chan_t'($urandom);
		cmd.green = chan_t'($urandom);
		cmd.blue  = chan_t'($urandom);
		case ($urandom_range(0, 9))
			0: cmd.bright = '0;
			1: cmd.bright = '1;
			default: cmd.bright = chan_t'($urandom);
		endcase
		cmd.typed = 1'b0;
		cmd.frame = '0;
		return cmd;
	endfunction

	function automatic int random_gap(input bit burst);
		int pick;
		if (burst)
			return 0;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 26);
		return $urandom_range(27, 90);
	endfunction

	function automatic tick_t phase_ticks(input int phase, input reg_idx_t idx);
		case (phase)
			0: return (idx == REG_ZERO_LOW || idx == REG_ONE_HIGH) ? TICK_MAX : '0;
			1: return (idx == REG_ZERO_LOW || idx == REG_ONE_HIGH) ? '0 : TICK_MAX;
			2: return '0;
			3: return TICK_MAX;
			default: return tick_t'($urandom);
		endcase
	endfunction

	task automatic send_colour(input colour_cmd_t cmd, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start  <= 1'b1;
		red    <= cmd.red;
		green  <= cmd.green;
		blue   <= cmd.blue;
		bright <= cmd.bright;
		do @(posedge clk); while (busy);
		push_frame(cmd.typed ? cmd.frame : scaled_frame(cmd));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input tick_t value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		// upper bits are noise, only the tick field is kept
		pwdata  <= {(DATA_W - TICK_W)'($urandom), value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		tick_regs[idx] = value;
	endtask

	task automatic check_all_regs();
		reg_idx_t idx;
		for (int i = 0; i < NUM_REGS; i++) begin
			idx = reg_idx_t'(i);
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b0;
			paddr   <= ADDR_W'({idx, 2'b00});
			@(posedge clk);
			penable <= 1'b1;
			do @(posedge clk); while (!pready);
			if (prdata !== DATA_W'(tick_regs[idx]))
				report_mismatch($sformatf("read of %s gave %0h, expected %0h",
					idx.name(), prdata, tick_regs[idx]));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	always @(posedge clk) begin : beat_check
		pulse_beat_t want;
		if (arst_n && strobe) begin
			if (beats_due.size() == 0) begin
				report_mismatch("pulse beat with none expected");
			end else begin
				want = beats_due.pop_front();
				if (high_ticks !== want.high_ticks)
					report_mismatch($sformatf("high_ticks %0d, expected %0d",
						high_ticks, want.high_ticks));
				if (low_ticks !== want.low_ticks)
					report_mismatch($sformatf("low_ticks %0d, expected %0d",
						low_ticks, want.low_ticks));
				if (bit_value !== want.bit_value)
					report_mismatch($sformatf("bit_value %b, expected %b",
						bit_value, want.bit_value));
				if (last_bit !== want.last_bit)
					report_mismatch($sformatf("last_bit %b, expected %b",
						last_bit, want.last_bit));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL rgb_led_pulse_encoder");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		bit burst;
		burst = 1'b0;
		tick_regs[REG_ZERO_HIGH] = 14;
		tick_regs[REG_ZERO_LOW]  = 32;
		tick_regs[REG_ONE_HIGH]  = 28;
		tick_regs[REG_ONE_LOW]   = 24;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_all_regs();

		foreach (DIRECTED_CMDS[i])
			send_colour(DIRECTED_CMDS[i], random_gap(1'b0));

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			for (int i = 0; i < NUM_REGS; i++)
				reg_write(reg_idx_t'(i), phase_ticks(phase, reg_idx_t'(i)));
			check_all_regs();
			for (int n = 0; n < RANDOM_CMDS; n++) begin
				// stretches of back-to-back commands
				if (n % 16 == 0)
					burst = ($urandom_range(0, 2) == 0);
				send_colour(random_colour(), random_gap(burst));
			end
		end

		wait_drained();
		if (fail_count == 0)
			$display("PASS rgb_led_pulse_encoder");
		else
			$display("FAIL rgb_led_pulse_encoder");
		$finish;
	end

endmodule

// ===== rgb_led_pulse_encoder.f =====
rtl/core/rgbenc_pkg.sv
rtl/core/rgb_led_pulse_encoder.sv
rtl/core/rgbenc_checker.sv
test/tb_rgb_led_pulse_encoder.sv
